>>> hdl/windowed_io_bandwidth_monitor_top_defines.svh
// Assertion macros for the windowed I/O bandwidth monitor.
`ifndef WINDOWED_IO_BANDWIDTH_MONITOR_TOP_DEFINES_SVH
`define WINDOWED_IO_BANDWIDTH_MONITOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define WIBM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define WIBM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/wibm_pkg.sv
// Shared types and constants of the windowed I/O bandwidth monitor.
`default_nettype none

package wibm_pkg;

   // Field widths
   localparam int unsigned PG_BYTES_W   = 17;
   localparam int unsigned PAGE_COUNT_W = 16;
   localparam int unsigned LATENCY_W    = 32;

   // Page size after reset
   localparam logic [PG_BYTES_W-1:0] PG_BYTES_RESET = 17'd4096;

   // 1e6 = 15625 * 2^6; the divisor scale is 2^12, so the dividend drops 6 bits
   localparam logic [13:0]  US_PER_S_ODD = 14'd15625;
   localparam int unsigned  DVD_SHIFT    = 6;

   // Depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // One completed I/O as it waits in the queue
   typedef struct packed {
      logic                    func;
      logic [PAGE_COUNT_W-1:0] page_count;
      logic [LATENCY_W-1:0]    latency_us;
   } wibm_item_type;

   // One result transfer
   typedef struct packed {
      logic        direction;
      logic [47:0] bandwidth_q8;
      logic [36:0] window_latency_total;
      logic [20:0] window_page_total;
   } wibm_result_type;

   // Back-end sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_MUL_PAGES,
      ST_MUL_SCALE,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_DELIVER
   } wibm_state_type;

endpackage

`default_nettype wire

>>> hdl/wibm_front.sv
// Front end: accepts completions and queues them for the back end.
`default_nettype none

module wibm_front import wibm_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_func,
   input  wire logic [PAGE_COUNT_W-1:0] req_page_count,
   input  wire logic [LATENCY_W-1:0]    req_latency_us,
   output logic                         q_valid,
   output wibm_item_type                q_item,
   input  wire logic                    q_pop
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   wibm_item_type    entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   wibm_item_type    item_new;

   // Pack the incoming completion
   always_comb begin
      item_new.func       = req_func;
      item_new.page_count = req_page_count;
      item_new.latency_us = req_latency_us;
   end

   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_item    = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

`default_nettype wire

>>> hdl/wibm_divider.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module wibm_divider #(
   parameter int unsigned DVD_W = 46,
   parameter int unsigned DVS_W = 37
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic [DVD_W-1:0]      quotient
);

   localparam int unsigned CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;

   assign done     = busy_ff && (cnt_ff == CNT_W'(1));
   assign quotient = dvd_ff;

   // One shift-subtract step; quotient bits shift in behind the dividend
   always_comb begin
      trial   = {rem_ff, dvd_ff[DVD_W-1]};
      diff    = trial - {1'b0, divisor};
      fits    = (trial >= {1'b0, divisor});
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

endmodule

`default_nettype wire

>>> hdl/wibm_back.sv
// Back end: window rings, running sums, scaling multiplies and the divide.
`default_nettype none

module wibm_back import wibm_pkg::*; #(
   parameter int unsigned WINDOW_DEPTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [PG_BYTES_W-1:0]  pg_bytes,
   input  wire logic                   q_valid,
   input  wire wibm_item_type          q_item,
   output logic                        q_pop,
   output logic                        res_valid,
   input  wire logic                   res_ready,
   output wibm_result_type             result
);

   localparam int unsigned SLOT_W    = $clog2(WINDOW_DEPTH);
   localparam int unsigned LAT_SUM_W = LATENCY_W + SLOT_W;
   localparam int unsigned PG_SUM_W  = PAGE_COUNT_W + SLOT_W;
   localparam int unsigned P1_W      = PG_BYTES_W + PG_SUM_W;
   localparam int unsigned ODD_W     = $bits(US_PER_S_ODD);
   localparam int unsigned P2_W      = P1_W + ODD_W;
   localparam int unsigned DVD_W     = P2_W - DVD_SHIFT;
   localparam int unsigned ENTRY_W   = LATENCY_W + PAGE_COUNT_W;
   localparam int unsigned MEM_DEPTH = 2 ** (SLOT_W + 1);

   wibm_state_type         state_ff, state_in;
   wibm_item_type          item_ff, item_in;
   logic [SLOT_W-1:0]      slot_ff [2];
   logic [1:0]             wrapped_ff;
   logic [LAT_SUM_W-1:0]   lat_sum_ff [2];
   logic [PG_SUM_W-1:0]    pg_sum_ff [2];
   logic [LAT_SUM_W-1:0]   cur_lat_ff, cur_lat_in;
   logic [PG_SUM_W-1:0]    cur_pg_ff, cur_pg_in;
   logic [P1_W-1:0]        prod1_ff, prod1_in;
   logic [P2_W-1:0]        prod2_ff, prod2_in;
   logic [ENTRY_W-1:0]     ring_mem [MEM_DEPTH];
   logic [ENTRY_W-1:0]     rd_data_ff;
   logic                   mem_rd_en;
   logic [SLOT_W:0]        mem_rd_addr;
   logic                   commit;
   logic [SLOT_W:0]        mem_wr_addr;
   logic [ENTRY_W-1:0]     mem_wr_data;
   logic [SLOT_W-1:0]      slot_cur, slot_next;
   logic                   slot_last;
   logic [LATENCY_W-1:0]   old_lat;
   logic [PAGE_COUNT_W-1:0] old_pg;
   logic                   div_start;
   logic                   div_done;
   logic [DVD_W-1:0]       quotient;
   logic [DVD_W+47:0]      quot_ext;
   logic [LAT_SUM_W+36:0]  lat_ext;
   logic [PG_SUM_W+20:0]   pg_ext;

   // Ring slot bookkeeping for the item in work
   assign slot_cur  = slot_ff[item_ff.func];
   assign slot_last = (slot_cur == SLOT_W'(WINDOW_DEPTH - 1));
   assign slot_next = slot_last ? '0 : slot_cur + 1'b1;

   // An entry never written since reset reads as zero
   assign old_lat = wrapped_ff[item_ff.func] ? rd_data_ff[ENTRY_W-1:PAGE_COUNT_W] : '0;
   assign old_pg  = wrapped_ff[item_ff.func] ? rd_data_ff[PAGE_COUNT_W-1:0] : '0;

   assign mem_rd_addr = {q_item.func, slot_ff[q_item.func]};
   assign mem_wr_addr = {item_ff.func, slot_cur};
   assign mem_wr_data = {item_ff.latency_us, item_ff.page_count};

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      cur_lat_in = cur_lat_ff;
      cur_pg_in  = cur_pg_ff;
      prod1_in   = prod1_ff;
      prod2_in   = prod2_ff;
      q_pop      = 1'b0;
      mem_rd_en  = 1'b0;
      commit     = 1'b0;
      div_start  = 1'b0;
      res_valid  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               mem_rd_en = 1'b1;
               item_in   = q_item;
               state_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            commit     = 1'b1;
            cur_lat_in = lat_sum_ff[item_ff.func] - LAT_SUM_W'(old_lat)
                         + LAT_SUM_W'(item_ff.latency_us);
            cur_pg_in  = pg_sum_ff[item_ff.func] - PG_SUM_W'(old_pg)
                         + PG_SUM_W'(item_ff.page_count);
            state_in   = ST_MUL_PAGES;
         end
         ST_MUL_PAGES: begin
            prod1_in = {{PG_SUM_W{1'b0}}, pg_bytes} * {{PG_BYTES_W{1'b0}}, cur_pg_ff};
            state_in = ST_MUL_SCALE;
         end
         ST_MUL_SCALE: begin
            prod2_in = {{ODD_W{1'b0}}, prod1_ff} * {{P1_W{1'b0}}, US_PER_S_ODD};
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (div_done) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and window sums
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_ff[0]    <= '0;
         slot_ff[1]    <= '0;
         wrapped_ff    <= '0;
         lat_sum_ff[0] <= '0;
         lat_sum_ff[1] <= '0;
         pg_sum_ff[0]  <= '0;
         pg_sum_ff[1]  <= '0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            slot_ff[item_ff.func]    <= slot_next;
            wrapped_ff[item_ff.func] <= wrapped_ff[item_ff.func] | slot_last;
            lat_sum_ff[item_ff.func] <= cur_lat_in;
            pg_sum_ff[item_ff.func]  <= cur_pg_in;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      cur_lat_ff <= cur_lat_in;
      cur_pg_ff  <= cur_pg_in;
      prod1_ff   <= prod1_in;
      prod2_ff   <= prod2_in;
   end

   // Ring memory, both directions, registered read
   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         rd_data_ff <= ring_mem[mem_rd_addr];
      end
      if (commit) begin
         ring_mem[mem_wr_addr] <= mem_wr_data;
      end
   end

   wibm_divider #(
      .DVD_W (DVD_W),
      .DVS_W (LAT_SUM_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod2_ff[P2_W-1:DVD_SHIFT]),
      .divisor  (cur_lat_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Result: zero for an empty latency sum, saturate above 48 bits
   assign quot_ext = {48'd0, quotient};
   assign lat_ext  = {37'd0, cur_lat_ff};
   assign pg_ext   = {21'd0, cur_pg_ff};

   always_comb begin
      result.direction            = item_ff.func;
      result.window_latency_total = lat_ext[36:0];
      result.window_page_total    = pg_ext[20:0];
      if (cur_lat_ff == '0) begin
         result.bandwidth_q8 = '0;
      end else if (quot_ext[DVD_W+47:48] != '0) begin
         result.bandwidth_q8 = '1;
      end else begin
         result.bandwidth_q8 = quot_ext[47:0];
      end
   end

endmodule

`default_nettype wire

>>> hdl/windowed_io_bandwidth_monitor_top.sv
// Windowed I/O bandwidth monitor: top level with config and output registers.
//
// Usage: every completed I/O is sent as one transfer on the req_ channel
// (direction, page count, latency in us). Each transfer yields exactly one
// rsp_ transfer with that direction's bandwidth over the last WINDOW_DEPTH
// completions (MB/s, 8 fraction bits, saturating) and the window sums.
// csr_write_enable/csr_write_data set the page size in bytes (4096 after
// reset); write it only while no completion is in flight.
// The serial divider works on a dividend of DW = 41 + log2(WINDOW_DEPTH)
// bits (46 at the default depth), produces one quotient bit per cycle and
// sets the throughput: the back end takes no new completion until it has
// handed over the last result. A two-entry queue takes new completions
// while one is in work.
// Reset clears the rings (through per-direction fill tracking), the sums,
// the slot pointers and the queue; no clearing pass is needed.
// If rsp_ready is low, the result waits in the output register; the back end
// finishes its next item and then holds, and the queue then fills and drops
// req_ready.
`default_nettype none

`include "windowed_io_bandwidth_monitor_top_defines.svh"

module windowed_io_bandwidth_monitor_top import wibm_pkg::*; #(
   parameter int unsigned WINDOW_DEPTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_func,
   input  wire logic [PAGE_COUNT_W-1:0] req_page_count,
   input  wire logic [LATENCY_W-1:0]    req_latency_us,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_direction,
   output logic [47:0]                  rsp_bandwidth_q8,
   output logic [36:0]                  rsp_window_latency_total,
   output logic [20:0]                  rsp_window_page_total,
   input  wire logic                    csr_write_enable,
   input  wire logic [PG_BYTES_W-1:0]   csr_write_data
);

   logic [PG_BYTES_W-1:0]  pg_bytes_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   wibm_result_type        rsp_data_ff;
   logic                   q_valid;
   wibm_item_type          q_item;
   logic                   q_pop;
   logic                   res_valid;
   logic                   res_ready;
   wibm_result_type        result;

   // Page size register
   always_ff @(posedge clock) begin
      if (reset) begin
         pg_bytes_ff <= PG_BYTES_RESET;
      end else if (csr_write_enable) begin
         pg_bytes_ff <= csr_write_data;
      end
   end

   wibm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_page_count (req_page_count),
      .req_latency_us (req_latency_us),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   wibm_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pg_bytes  (pg_bytes_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .result    (result)
   );

   // Output register
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_direction            = rsp_data_ff.direction;
   assign rsp_bandwidth_q8         = rsp_data_ff.bandwidth_q8;
   assign rsp_window_latency_total = rsp_data_ff.window_latency_total;
   assign rsp_window_page_total    = rsp_data_ff.window_page_total;

   // Checks
   `WIBM_ASSERT_NOW(a_pop_needs_item, q_pop, q_valid, "back end popped an empty queue")
   `WIBM_ASSERT_NEXT(a_push_fills_queue, req_valid && req_ready, q_valid, "transfer not queued")
   `WIBM_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid, "stalled result dropped")

endmodule

`default_nettype wire
